// ===== rtl/core/vwrd_pkg.sv =====
// shared types and constants for the volume weighted random draw block
package vwrd_pkg;
  localparam int MaxGrains = 64;
  localparam int IdxW = $clog2(MaxGrains);
  localparam int CntW = IdxW + 1;
  localparam int CumW = 16 + IdxW;
  localparam int MatW = 144;

  localparam logic [0:0] OpLoad = 1'b0;
  localparam logic [0:0] OpDraw = 1'b1;

  localparam logic [0:0] RegGrainCount = 1'b0;
  localparam logic [0:0] RegSampleCount = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_wr;      // write grain at load counter
    logic sort_clear;   // reset sort indices
    logic sort_step;    // one compare step of the sort
    logic sort_place;   // write best into rank table, sum cumulative
    logic srch_init;    // open binary search
    logic srch_step;    // one search step
    logic fetch;        // read matrix of the chosen grain
    logic emit;         // drive result strobe
  } vwrd_cmd_t;

  typedef struct packed {
    logic scan_done;    // scan index passed last grain
    logic srch_done;    // search interval closed
  } vwrd_sts_t;
endpackage

// ===== rtl/core/vwrd_ram.sv =====
// generic simple dual port ram (one write port, one read port) with registered read
module vwrd_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/vwrd_datapath.sv =====
// grain stores, selection sort, cumulative sum and binary search datapath
module vwrd_datapath (
  input  logic                      clk,
  input  vwrd_pkg::vwrd_cmd_t       cmd,
  output vwrd_pkg::vwrd_sts_t       sts,
  input  logic [vwrd_pkg::CntW-1:0] load_idx,
  input  logic [vwrd_pkg::CntW-1:0] set_n,
  input  logic [vwrd_pkg::CntW-1:0] place_pos,
  input  logic [15:0]               datum,
  input  logic [vwrd_pkg::MatW-1:0] mat_in,
  output logic [vwrd_pkg::MatW-1:0] mat_out,
  output logic [5:0]                rank_out
);
  localparam int IW = vwrd_pkg::IdxW;
  localparam int CW = vwrd_pkg::CntW;
  localparam int SW = vwrd_pkg::CumW;

  logic [CW-1:0] scan, scan_q, best;
  logic          found, cmp_v, issue, first_pass;
  logic [15:0]   best_frac;
  logic [SW-1:0] sum, total;
  logic [CW-1:0] lo, hi;
  logic [15:0]   key;
  logic [IW-1:0] rank_raddr;
  logic [IW-1:0] rank_rd;
  logic [SW-1:0] cum_rd;
  logic [CW-1:0] mid;
  logic [IW-1:0] mid_q;
  logic          phase;  // search step: 0 issue read, 1 compare
  logic          fr_we;
  logic [IW-1:0] fr_waddr;
  logic [16:0]   fr_wdata, fr_rd;  // {taken, fraction}
  logic          taken_rd;
  logic [15:0]   frac_rd;

  assign mid = CW'((lo + hi) >> 1);
  assign issue = cmd.sort_step && (scan < set_n);
  // the first scan visits every grain untaken, so it also forms the total
  assign first_pass = (place_pos == CW'(set_n - 1'b1));
  assign {taken_rd, frac_rd} = fr_rd;

  always_ff @(posedge clk) begin
    cmp_v <= issue;
    if (cmd.sort_clear) begin
      scan <= '0; found <= 1'b0; best <= '0; best_frac <= '0;
      sum <= '0; total <= '0;
    end
    if (issue) begin
      scan_q <= scan;
      scan <= CW'(scan + 1'b1);
    end
    if (cmp_v) begin
      if (first_pass) total <= SW'(total + SW'(frac_rd));
      if (!taken_rd && (!found || frac_rd > best_frac)) begin
        best <= scan_q; best_frac <= frac_rd; found <= 1'b1;
      end
    end
    if (cmd.sort_place) begin
      sum <= SW'(sum + SW'(best_frac));
      scan <= '0; found <= 1'b0;
    end
    if (cmd.srch_init) begin
      lo <= '0; hi <= CW'(set_n - 1'b1); key <= datum; phase <= 1'b0;
    end
    if (cmd.srch_step) begin
      phase <= ~phase;
      if (!phase) mid_q <= mid[IW-1:0];
      else if (cum_rd < SW'(key)) lo <= CW'({1'b0, mid_q} + 1'b1);
      else hi <= CW'({1'b0, mid_q});
    end
  end

  // fraction store with taken flag: loads clear it, placing a grain sets it
  assign fr_we    = cmd.load_wr || cmd.sort_place;
  assign fr_waddr = cmd.load_wr ? load_idx[IW-1:0] : best[IW-1:0];
  assign fr_wdata = cmd.load_wr ? {1'b0, datum} : {1'b1, best_frac};

  vwrd_ram #(.Width(17), .Depth(vwrd_pkg::MaxGrains)) u_frac (
    .clk, .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(scan[IW-1:0]), .rdata(fr_rd));

  // ranks are placed from highest to lowest, so cumulative(pos) is the
  // total less the weights placed above pos
  assign rank_raddr = cmd.fetch ? lo[IW-1:0] : mid[IW-1:0];

  vwrd_ram #(.Width(IW), .Depth(vwrd_pkg::MaxGrains)) u_rank (
    .clk, .we(cmd.sort_place), .waddr(place_pos[IW-1:0]), .wdata(best[IW-1:0]),
    .raddr(rank_raddr), .rdata(rank_rd));
  vwrd_ram #(.Width(SW), .Depth(vwrd_pkg::MaxGrains)) u_cum (
    .clk, .we(cmd.sort_place), .waddr(place_pos[IW-1:0]), .wdata(SW'(total - sum)),
    .raddr(mid[IW-1:0]), .rdata(cum_rd));

  logic [IW-1:0] lo_q;
  always_ff @(posedge clk) if (cmd.fetch) lo_q <= lo[IW-1:0];
  assign rank_out = 6'(lo_q);

  vwrd_ram #(.Width(vwrd_pkg::MatW), .Depth(vwrd_pkg::MaxGrains)) u_mat (
    .clk, .we(cmd.load_wr), .waddr(load_idx[IW-1:0]), .wdata(mat_in),
    .raddr(rank_rd), .rdata(mat_out));

  assign sts.scan_done = (scan >= set_n) && !cmp_v;
  assign sts.srch_done = (lo >= hi) && !phase;
endmodule

// ===== rtl/core/vwrd_ctrl.sv =====
// controller state machine: load, sort, draw sequencing
module vwrd_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      op,
  input  logic [6:0]                grain_count,
  input  logic [9:0]                sample_count,
  input  vwrd_pkg::vwrd_sts_t       sts,
  output vwrd_pkg::vwrd_cmd_t       cmd,
  output logic                      busy,
  output logic [vwrd_pkg::CntW-1:0] load_idx,
  output logic [vwrd_pkg::CntW-1:0] set_n,
  output logic [vwrd_pkg::CntW-1:0] place_pos,
  output logic                      last
);
  localparam int CW = vwrd_pkg::CntW;
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_PLACE = 7'b0000100,
    S_SRCH = 7'b0001000, S_FETCH = 7'b0010000, S_WAIT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;
  state_t state, state_next;
  logic ready, last_q;
  logic [CW-1:0] placed, eff;
  logic [9:0] draws, draws_inc, target;

  always_comb begin
    if (grain_count == '0) eff = CW'(1);
    else if (grain_count > 7'(vwrd_pkg::MaxGrains)) eff = CW'(vwrd_pkg::MaxGrains);
    else eff = CW'(grain_count);
  end
  assign draws_inc = 10'(draws + 1'b1);
  assign target = (sample_count == '0) ? 10'(set_n) : sample_count;
  assign place_pos = CW'(set_n - placed - 1'b1);

  logic acc;
  assign acc = start && !busy;
  assign busy = (state != S_IDLE);
  assign last = last_q;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && op == vwrd_pkg::OpLoad && !ready) begin
          cmd.load_wr = 1'b1;
          if (CW'(load_idx + 1'b1) >= eff) begin
            cmd.sort_clear = 1'b1; state_next = S_SCAN;
          end
        end else if (acc && op == vwrd_pkg::OpDraw && ready) begin
          cmd.srch_init = 1'b1; state_next = S_SRCH;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_PLACE;
        else cmd.sort_step = 1'b1;
      end
      S_PLACE: begin
        cmd.sort_place = 1'b1;
        state_next = (CW'(placed + 1'b1) >= set_n) ? S_IDLE : S_SCAN;
      end
      S_SRCH: begin
        if (sts.srch_done) begin cmd.fetch = 1'b1; state_next = S_FETCH; end
        else cmd.srch_step = 1'b1;
      end
      S_FETCH: state_next = S_WAIT;
      S_WAIT:  state_next = S_EMIT;
      S_EMIT: begin cmd.emit = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ready <= 1'b0; load_idx <= '0; draws <= '0;
      placed <= '0; set_n <= CW'(1); last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_wr) begin
        load_idx <= CW'(load_idx + 1'b1);
        if (cmd.sort_clear) set_n <= eff;
      end
      if (cmd.sort_clear) placed <= '0;
      if (cmd.sort_place) begin
        placed <= CW'(placed + 1'b1);
        if (CW'(placed + 1'b1) >= set_n) begin
          ready <= 1'b1; load_idx <= '0; draws <= '0;
        end
      end
      if (cmd.srch_init) begin
        if (draws_inc >= target || draws_inc == '0) begin
          last_q <= 1'b1; ready <= 1'b0; draws <= '0; load_idx <= '0;
        end else begin
          last_q <= 1'b0; draws <= draws_inc;
        end
      end
    end
  end
endmodule

// ===== rtl/core/volume_weighted_random_draw.sv =====
// top level of the volume weighted random draw block
// usage:
//   configuration goes through the apb port: grain_count at 0x0, sample_count
//   at 0x4; write only while busy is low
//   an item is taken when start is high and busy is low; op selects a grain
//   load (0) or a draw (1); matrix inputs matter on loads only
//   a load is written as it is taken and leaves busy low, but the load that
//   completes a set starts the sort, a selection sort: for each rank a scan
//   over all loaded grains (one ram read a cycle, a drain of the last read
//   and a done check) then a place step, busy high throughout
//   a draw runs a binary search over cumulative weights (each step a ram
//   read then a compare), then reads the rank and matrix stores for the
//   result beat; busy drops the cycle after the beat, so draws do not overlap
//   the result beat shows for one cycle with valid high; the receiver
//   cannot stall, so the beat is simply presented
//   last_sample marks the final draw of a set; after it loads start again
//   loads during a draw phase and draws during loading give no beat
//   reset returns the block to the loading phase with registers at default
module volume_weighted_random_draw (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:2]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [15:0]        datum,
  input  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic               valid,
  output logic signed [15:0] o00, o01, o02, o10, o11, o12, o20, o21, o22,
  output logic [5:0]         sorted_rank,
  output logic               last_sample
);
  logic [6:0] grain_count;
  logic [9:0] sample_count;
  vwrd_pkg::vwrd_cmd_t cmd;
  vwrd_pkg::vwrd_sts_t sts;
  logic [vwrd_pkg::CntW-1:0] load_idx, set_n, place_pos;
  logic [vwrd_pkg::MatW-1:0] mat_out;
  logic last;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grain_count <= 7'd50; sample_count <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == vwrd_pkg::RegGrainCount) grain_count <= pwdata[6:0];
      else sample_count <= pwdata[9:0];
    end
  end
  assign prdata = (paddr == vwrd_pkg::RegSampleCount) ? {22'd0, sample_count}
                                                     : {25'd0, grain_count};

  vwrd_ctrl u_ctrl (
    .clk, .rst, .start, .op, .grain_count, .sample_count, .sts, .cmd, .busy,
    .load_idx, .set_n, .place_pos, .last);

  vwrd_datapath u_dp (
    .clk, .cmd, .sts, .load_idx, .set_n, .place_pos, .datum,
    .mat_in({m00, m01, m02, m10, m11, m12, m20, m21, m22}),
    .mat_out, .rank_out(sorted_rank));

  // result beat
  assign valid = cmd.emit;
  assign last_sample = last;
  assign {o00, o01, o02, o10, o11, o12, o20, o21, o22} = mat_out;
endmodule

// ===== rtl/core/vwrd_checker.sv =====
// port level checks for the volume weighted random draw block
module vwrd_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic valid,
  input logic pready
);
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
  a_no_valid_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy)) else $error("beat without work");
  a_single: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("double beat");
  a_free_after: assert property (@(posedge clk) disable iff (rst)
    valid |=> !busy) else $error("busy after beat");
  a_take_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !valid) else $error("beat right after a taken item");
endmodule

bind volume_weighted_random_draw vwrd_checker u_chk (
  .clk, .rst, .start, .busy, .valid, .pready);

// ===== verif/tb_volume_weighted_random_draw.sv =====
// self-checking testbench for the volume weighted random draw block
module tb_volume_weighted_random_draw;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;   // watchdog bound, above the busy time of a full 64-grain sort

  // one draw result: matrix entry j sits at mat[j], row major (o00 first)
  typedef struct packed {
    logic [8:0][15:0] mat;
    logic [5:0]       rank;
    logic             last;
  } pick_t;

  // directed stimulus row: either a register write or one item
  typedef struct {
    bit        cfg;
    bit        reg_sel;
    int        value;
    bit        opc;
    bit [15:0] datum;
    bit [15:0] fill;     // load matrix entry j is fill ^ j
    bit        chk;      // expected beat typed in below
    bit [15:0] efill;
    bit [5:0]  erank;
    bit        elast;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:2] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic op = vwrd_pkg::OpLoad;
  logic [15:0] datum = '0;
  logic signed [15:0] m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
  logic signed [15:0] m20 = '0, m21 = '0, m22 = '0;
  logic valid;
  logic signed [15:0] o00, o01, o02, o10, o11, o12, o20, o21, o22;
  logic [5:0] sorted_rank;
  logic last_sample;

  volume_weighted_random_draw DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: own copy of registers and grain stores
  int        gc_reg = 50, sc_reg = 0;
  bit [15:0] frac [vwrd_pkg::MaxGrains];
  bit [8:0][15:0] mats [vwrd_pkg::MaxGrains];
  int        order [vwrd_pkg::MaxGrains];
  int        cum [vwrd_pkg::MaxGrains];
  int        loaded = 0, drawn = 0, set_n = 1;
  bit        drawing = 0;

  pick_t picks_due[$];
  int    mismatches = 0;
  int    beats_seen = 0, items_taken = 0, sets_done = 0, overruns = 0;
  int    idle_pct = 0;
  int    stall_cycles = 0;

  // rank grains by fraction ascending, earlier grain ranks higher on ties,
  // then build running sums over the ranked fractions
  function automatic void rank_grains(int n);
    bit used [vwrd_pkg::MaxGrains];
    int best, sum;
    foreach (used[k]) used[k] = 0;
    for (int pos = n - 1; pos >= 0; pos--) begin
      best = -1;
      for (int k = 0; k < n; k++)
        if (!used[k] && (best < 0 || frac[k] > frac[best])) best = k;
      used[best] = 1;
      order[pos] = best;
    end
    sum = 0;
    for (int pos = 0; pos < n; pos++) begin
      sum += frac[order[pos]];
      cum[pos] = sum;
    end
    set_n = n;
    drawn = 0;
    loaded = 0;
    drawing = 1;
    sets_done++;
  endfunction

  // advance the grain model by one accepted item; returns 1 with a pick on a draw of a ranked set
  function automatic bit grain_model_step(bit opc, bit [15:0] d, bit [8:0][15:0] m,
                                          output pick_t p);
    int n, r, target;
    p = '0;
    if (opc == vwrd_pkg::OpLoad) begin
      if (drawing) return 0;
      n = (gc_reg < 1) ? 1 : (gc_reg > vwrd_pkg::MaxGrains) ? vwrd_pkg::MaxGrains : gc_reg;
      if (loaded < vwrd_pkg::MaxGrains) begin
        frac[loaded] = d;
        mats[loaded] = m;
        loaded++;
      end
      if (loaded >= n) rank_grains(n);
      return 0;
    end
    if (!drawing) return 0;
    r = 0;
    while (r < set_n && cum[r] < d) r++;
    if (r >= set_n) begin
      r = set_n - 1;
      overruns++;
    end
    p.mat = mats[order[r]];
    p.rank = r[5:0];
    target = (sc_reg == 0) ? set_n : sc_reg;
    drawn = (drawn + 1) & 1023;
    p.last = (drawn >= target || drawn == 0);
    if (p.last) begin
      drawing = 0;
      drawn = 0;
      loaded = 0;
    end
    return 1;
  endfunction

  // present one item and hold it until the block takes it
  task automatic drive_item(bit opc, bit [15:0] d, bit [8:0][15:0] m, bit chk = 0,
                            pick_t typed = '0);
    pick_t p;
    bit has;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= opc;
    datum <= d;
    {m22, m21, m20, m12, m11, m10, m02, m01, m00} <= m;
    do @(posedge clk); while (busy);
    items_taken++;
    has = grain_model_step(opc, d, m, p);
    if (has) picks_due = {picks_due, (chk ? typed : p)};
    else if (chk) begin
      $error("directed row expected a beat but the item gives none");
      mismatches++;
    end
  endtask

  // register write over apb, only once the block has gone quiet
  task automatic write_reg(bit reg_sel, int value);
    start <= 1'b0;
    @(posedge clk);
    while (picks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);         // let a sort kicked off by the last load raise busy
    while (busy) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= reg_sel;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);                    // write lands at this edge
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == vwrd_pkg::RegGrainCount) gc_reg = value & 'h7f;
    else sc_reg = value & 'h3ff;
  endtask

  function automatic bit [8:0][15:0] fill_mat(bit [15:0] f);
    bit [8:0][15:0] m;
    for (int j = 0; j < 9; j++) m[j] = f ^ j[15:0];
    return m;
  endfunction

  function automatic bit [8:0][15:0] rand_mat();
    bit [8:0][15:0] m;
    for (int j = 0; j < 9; j++) m[j] = 16'($urandom());
    return m;
  endfunction

  // result checker: every beat against the oldest pending pick
  always @(posedge clk) begin
    pick_t act, want;
    if (!rst && valid) begin
      beats_seen++;
      act.mat = {o22, o21, o20, o12, o11, o10, o02, o01, o00};
      act.rank = sorted_rank;
      act.last = last_sample;
      if (picks_due.size() == 0) begin
        $error("result beat with no draw pending");
        mismatches++;
      end else begin
        want = picks_due.pop_front();
        for (int j = 0; j < 9; j++)
          if (act.mat[j] !== want.mat[j]) begin
            $error("o%0d%0d expected %0h actual %0h", j / 3, j % 3, want.mat[j], act.mat[j]);
            mismatches++;
          end
        if (act.rank !== want.rank) begin
          $error("sorted_rank expected %0d actual %0d", want.rank, act.rank);
          mismatches++;
        end
        if (act.last !== want.last) begin
          $error("last_sample expected %0d actual %0d", want.last, act.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with neither an item taken nor a beat seen
  always @(posedge clk) begin
    if ((start && !busy) || valid || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchLimit) begin
      $display("watchdog: no progress for %0d cycles", WatchLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // directed table: edges of the fields, ignored items, ties, overrun,
  // clamped set size, registers changed mid-set
  row_t directed [] = '{
    '{1, vwrd_pkg::RegGrainCount,  1, 0, 0, 0, 0, 0, 0, 0},
    '{1, vwrd_pkg::RegSampleCount, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'h1234, 0, 0, 0, 0, 0},          // draw while loading
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'hffff, 16'h7fff, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h0001, 16'h0000, 0, 0, 0, 0},   // load while drawing
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'h0000, 0, 1, 16'h7fff, 0, 1},
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h0000, 16'h8000, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'hffff, 0, 1, 16'h8000, 0, 1},   // overrun past all weights
    '{1, vwrd_pkg::RegGrainCount,  0, 0, 0, 0, 0, 0, 0, 0},         // zero counts as one
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h5555, 16'h1234, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'h5556, 0, 1, 16'h1234, 0, 1},
    '{1, vwrd_pkg::RegGrainCount,  3, 0, 0, 0, 0, 0, 0, 0},
    '{1, vwrd_pkg::RegSampleCount, 2, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h1000, 16'h0100, 0, 0, 0, 0},   // three-way tie
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h1000, 16'h0200, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h1000, 16'h0300, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'h1000, 0, 0, 0, 0, 0},
    '{1, vwrd_pkg::RegSampleCount, 1, 0, 0, 0, 0, 0, 0, 0},         // target lowered mid-set
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'h2500, 0, 0, 0, 0, 0},
    '{1, vwrd_pkg::RegGrainCount,  4, 0, 0, 0, 0, 0, 0, 0},
    '{1, vwrd_pkg::RegSampleCount, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h0010, 16'h0400, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h0020, 16'h0500, 0, 0, 0, 0},
    '{1, vwrd_pkg::RegGrainCount,  2, 0, 0, 0, 0, 0, 0, 0},         // set size shrunk mid-load
    '{0, 0, 0, vwrd_pkg::OpLoad, 16'h0030, 16'h0600, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'h0015, 0, 0, 0, 0, 0},
    '{0, 0, 0, vwrd_pkg::OpDraw, 16'hffff, 0, 0, 0, 0, 0}
  };

  // random phases: grain_count, sample_count, sets, sender idle percent
  int ph_gc   [] = '{5, 64, 127, 2,  1,  8, 16, 3};
  int ph_sc   [] = '{0, 0,  3,   30, 0,  5, 0,  7};
  int ph_sets [] = '{3, 1,  1,   1,  10, 2, 1,  3};
  int ph_idle [] = '{0, 72, 33,  0,  72, 0, 33, 0};

  initial begin
    pick_t typed;
    int n, target;
    bit [15:0] f, prev_f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].cfg) write_reg(directed[i].reg_sel, directed[i].value);
      else begin
        typed.mat = fill_mat(directed[i].efill);
        typed.rank = directed[i].erank;
        typed.last = directed[i].elast;
        drive_item(directed[i].opc, directed[i].datum, fill_mat(directed[i].fill),
                   directed[i].chk, typed);
      end
    end

    foreach (ph_gc[p]) begin
      write_reg(vwrd_pkg::RegGrainCount, ph_gc[p]);
      write_reg(vwrd_pkg::RegSampleCount, ph_sc[p]);
      idle_pct = ph_idle[p];
      n = (ph_gc[p] < 1) ? 1 : (ph_gc[p] > vwrd_pkg::MaxGrains) ? vwrd_pkg::MaxGrains
                                                                 : ph_gc[p];
      target = (ph_sc[p] == 0) ? n : ph_sc[p];
      prev_f = 16'($urandom());
      for (int s = 0; s < ph_sets[p]; s++) begin
        // well-formed set with an occasional stray draw during loading and stray load during drawing
        for (int g = 0; g < n; g++) begin
          if ($urandom_range(9) == 0) drive_item(vwrd_pkg::OpDraw, 16'($urandom()), rand_mat());
          case ($urandom_range(9))
            0: f = 16'h0000;
            1: f = 16'hffff;
            2, 3: f = prev_f;                // force ties
            4: f = 16'($urandom_range(15));
            default: f = 16'($urandom());
          endcase
          prev_f = f;
          drive_item(vwrd_pkg::OpLoad, f, rand_mat());
        end
        for (int d = 0; d < target; d++) begin
          if ($urandom_range(9) == 0) drive_item(vwrd_pkg::OpLoad, 16'($urandom()), rand_mat());
          // one phase holds off each draw until the previous beat has come
          if (p == 5) begin
            start <= 1'b0;
            @(posedge clk);
            while (picks_due.size() != 0) @(posedge clk);
          end
          drive_item(vwrd_pkg::OpDraw, ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom()),
                     rand_mat());
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (picks_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d items, %0d sets ranked, %0d draw beats checked",
             items_taken, sets_done, beats_seen);
    $display("overruns %0d, set sizes 1..64, draw targets up to 64", overruns);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/vwrd_pkg.sv
rtl/core/vwrd_ram.sv
rtl/core/vwrd_datapath.sv
rtl/core/vwrd_ctrl.sv
rtl/core/volume_weighted_random_draw.sv
rtl/core/vwrd_checker.sv
verif/tb_volume_weighted_random_draw.sv
